/* hw/rtl/pmsfp_pkg.sv */
// Shared types and constants for the particulate sensor frame parser.
`default_nettype none

package pmsfp_pkg;

  localparam logic [7:0] HdrA         = 8'h42;
  localparam logic [7:0] HdrB         = 8'h4D;
  localparam int         SumSpan      = 30;
  localparam int         FirstWordPos = 4;
  localparam int         LastWordPos  = 28;
  localparam int         WordCount    = 13;

  localparam int PosW  = 5;
  localparam int IdxW  = 4;
  localparam int WordW = 16;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(WordCount - 1);

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_SYNC,
    ST_COLLECT,
    ST_READ,
    ST_LOAD
  } pmsfp_state_e;

  typedef struct packed {
    logic            take;
    logic            sum_init;
    logic            sum_add;
    logic            mem_wr;
    logic            rd_en;
    logic            out_ld;
    logic [PosW-1:0] pos;
    logic [IdxW-1:0] idx;
  } pmsfp_cmd_t;

  typedef struct packed {
    logic hdr_a;
    logic hdr_b;
    logic sum_ok;
    logic out_free;
  } pmsfp_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/pmsfp_in_if.sv */
// Byte input channel: valid/ready handshake carrying one received byte.
`default_nettype none

interface pmsfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

/* hw/rtl/pmsfp_out_if.sv */
// Result channel: valid/ready handshake carrying one decoded frame word.
`default_nettype none

interface pmsfp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  word_index;
  logic [15:0] word_value;
  logic        last_word;

  modport source (output valid, output word_index, output word_value,
                  output last_word, input ready);
  modport sink   (input valid, input word_index, input word_value,
                  input last_word, output ready);
endinterface

`default_nettype wire

/* hw/rtl/pmsfp_ctrl.sv */
// Parser controller: sync hunt, byte position, enable register, word readout.
`default_nettype none

module pmsfp_ctrl
  import pmsfp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  pmsfp_sts_t sts_i,
  output pmsfp_cmd_t cmd_o
);

  pmsfp_state_e    state_q, state_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            enable_q;
  logic            take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_HUNT;
      pos_q    <= '0;
      idx_q    <= '0;
      enable_q <= 1'b1;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      idx_q   <= idx_d;
      if (cfg_we_i) begin
        enable_q <= cfg_data_i;
      end
    end
  end

  assign take = in_valid_i && in_ready_o && enable_q;

  always_comb begin
    state_d        = state_q;
    pos_d          = pos_q;
    idx_d          = idx_q;
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    cmd_o.pos      = pos_q;
    cmd_o.idx      = idx_q;
    unique case (state_q)
      ST_HUNT: begin
        in_ready_o = 1'b1;
        if (take && sts_i.hdr_a) begin
          cmd_o.take     = 1'b1;
          cmd_o.sum_init = 1'b1;
          pos_d          = PosW'(1);
          state_d        = ST_SYNC;
        end
      end
      ST_SYNC: begin
        in_ready_o = 1'b1;
        if (take) begin
          cmd_o.take = 1'b1;
          if (sts_i.hdr_b) begin
            cmd_o.sum_add = 1'b1;
            pos_d         = PosW'(2);
            state_d       = ST_COLLECT;
          end else if (sts_i.hdr_a) begin
            cmd_o.sum_init = 1'b1;
            pos_d          = PosW'(1);
          end else begin
            pos_d   = '0;
            state_d = ST_HUNT;
          end
        end
      end
      ST_COLLECT: begin
        in_ready_o = 1'b1;
        if (take) begin
          cmd_o.take    = 1'b1;
          cmd_o.sum_add = (pos_q < PosW'(SumSpan));
          cmd_o.mem_wr  = pos_q[0] && (pos_q >= PosW'(FirstWordPos + 1))
                          && (pos_q <= PosW'(LastWordPos + 1));
          pos_d         = pos_q + PosW'(1);
          if (pos_q == '1) begin
            idx_d   = '0;
            state_d = sts_i.sum_ok ? ST_READ : ST_HUNT;
          end
        end
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_LOAD;
      end
      ST_LOAD: begin
        if (sts_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          if (idx_q == LastIdx) begin
            idx_d   = '0;
            state_d = ST_HUNT;
          end else begin
            idx_d   = idx_q + IdxW'(1);
            state_d = ST_READ;
          end
        end
      end
      default: begin
        state_d = ST_HUNT;
        pos_d   = '0;
      end
    endcase
  end

  a_hunt_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HUNT) |-> (pos_q == '0))
    else $error("position not cleared while hunting");

  a_wr_odd_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mem_wr |-> (pos_q[0] && state_q == ST_COLLECT))
    else $error("word store written at even byte position");

  a_read_then_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |=> (state_q == ST_LOAD))
    else $error("read not followed by load");

  a_last_word_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.out_ld && idx_q == LastIdx) |=> (state_q == ST_HUNT && idx_q == '0))
    else $error("frame readout did not end after last word");

endmodule

`default_nettype wire

/* hw/rtl/pmsfp_dp.sv */
// Parser datapath: header compare, running checksum, word store, output register.
`default_nettype none

module pmsfp_dp
  import pmsfp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [7:0]       rx_byte_i,
  input  pmsfp_cmd_t       cmd_i,
  output pmsfp_sts_t       sts_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic [IdxW-1:0]  word_index_o,
  output logic [WordW-1:0] word_value_o,
  output logic             last_word_o
);

  logic [WordW-1:0] mem [WordCount];
  logic [WordW-1:0] sum_q;
  logic [7:0]       hi_q;
  logic [WordW-1:0] rd_data_q;
  logic             valid_q;
  logic [IdxW-1:0]  index_q;
  logic [WordW-1:0] value_q;
  logic             last_q;
  logic [IdxW-1:0]  wr_addr;

  assign wr_addr = cmd_i.pos[PosW-1:1] - IdxW'(FirstWordPos / 2);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr) begin
      mem[wr_addr] <= {hi_q, rx_byte_i};
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[cmd_i.idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      hi_q <= rx_byte_i;
    end
    if (cmd_i.sum_init) begin
      sum_q <= WordW'(rx_byte_i);
    end else if (cmd_i.sum_add) begin
      sum_q <= sum_q + WordW'(rx_byte_i);
    end
    if (cmd_i.out_ld) begin
      index_q <= cmd_i.idx;
      value_q <= rd_data_q;
      last_q  <= (cmd_i.idx == LastIdx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  assign sts_o.hdr_a    = (rx_byte_i == HdrA);
  assign sts_o.hdr_b    = (rx_byte_i == HdrB);
  assign sts_o.sum_ok   = (sum_q == {hi_q, rx_byte_i});
  assign sts_o.out_free = !valid_q || out_ready_i;

  assign out_valid_o  = valid_q;
  assign word_index_o = index_q;
  assign word_value_o = value_q;
  assign last_word_o  = last_q;

endmodule

`default_nettype wire

/* hw/rtl/pm_sensor_frame_parser.sv */
// Top level of the particulate sensor 32-byte frame parser.
// Each word is read out by a registered read of the word store, then a load into the
// output register that waits until the output is free. Throughput: 1 byte per cycle
// while enabled and receiving; a good frame then reads out 13 words, no input taken.
// Reset: hunting for the start byte, enable set, output empty; the word store is not
// cleared, since every word read out was written by the same frame.
`default_nettype none

module pm_sensor_frame_parser
  import pmsfp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_data_i,
  pmsfp_in_if.sink     rx_i,
  pmsfp_out_if.source  res_o
);

  pmsfp_cmd_t cmd;
  pmsfp_sts_t sts;

  pmsfp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (rx_i.valid),
    .in_ready_o (rx_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pmsfp_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_byte_i    (rx_i.rx_byte),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (res_o.ready),
    .out_valid_o  (res_o.valid),
    .word_index_o (res_o.word_index),
    .word_value_o (res_o.word_value),
    .last_word_o  (res_o.last_word)
  );

endmodule

`default_nettype wire
